// ===== rtl/core/tts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the target track state machine
// Coordinate widths, stream packing, register codes and state encoding.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Width of one signed 3D coordinate in mm.
    localparam int COORD_BITS = 16;
    localparam int PIX_W      = 12;
    localparam int LIM_W      = 16;
    localparam int PLIM_W     = 12;
    localparam int MISS_W     = 8;

    localparam int LIM_SQ_W   = 2 * LIM_W;
    localparam int PLIM_SQ_W  = 2 * PLIM_W;

    // Squared 3D distance: three squares of COORD_BITS-wide magnitudes.
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int SUM_W      = SQ_W + 2;
    localparam int CMP_W      = (COORD_BITS > LIM_W) ? COORD_BITS : LIM_W;
    localparam int SQ_CMP_W   = (SUM_W > LIM_SQ_W) ? SUM_W : LIM_SQ_W;
    localparam int PSUM_W     = 2 * PIX_W + 1;

    // Stream packing.
    localparam int S_FIELDS_W = 3 * COORD_BITS + 2 * PIX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT  = 2'd2;

    localparam logic [LIM_W-1:0]  SPACE_LIMIT_RST = 16'd200;
    localparam logic [PLIM_W-1:0] PIXEL_LIMIT_RST = 12'd50;
    localparam logic [MISS_W-1:0] MISS_LIMIT_RST  = 8'd10;

    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    typedef enum logic [2:0] {
        ST_LOST   = 3'd0,
        ST_FIRST  = 3'd1,
        ST_CONT   = 3'd2,
        ST_BUF    = 3'd3,
        ST_SWITCH = 3'd4
    } state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [PIX_W-1:0]             pix_x;
        logic [PIX_W-1:0]             pix_y;
    } target_t;

    typedef struct packed {
        logic    has_target;
        logic    spin_mode;
        target_t tgt;
    } item_t;

    typedef struct packed {
        logic [LIM_W-1:0]     space_lim;
        logic [LIM_SQ_W-1:0]  space_lim_sq;
        logic [PLIM_SQ_W-1:0] pix_lim_sq;
        logic [MISS_W-1:0]    miss_limit;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/target_track_state_machine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// target_track_state_machine: per-frame target track state machine
// One detection in, one track state and re-init flag out, per frame.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tdata: pos_x, pos_y, pos_z, pix_x, pix_y
//                                              s_tuser: has_target, spin_mode
//  m_        out        m_tvalid / m_tready    m_tdata: track_state, reinit_request
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  One transfer per cycle, sustained while m_tready stays high. A detection is
//  held in the input register, then the same-target test and state update run
//  combinationally into the result register, which drives m_tvalid. The loop through
//  the track state register (distance squares, add, compare, next state) sets
//  the clock. Reset (aresetn low, synchronous) empties both registers, returns
//  the track to lost with no previous target and loads the default limits.
//  A stalled m_ side holds the result; the input register still takes one more
//  transfer, then s_tready drops until the result moves on.
//
module target_track_state_machine
    import tts_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [59:48] pix_x, [71:60] pix_y
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] has_target, [1] spin_mode
    input  wire logic [S_TUSER_W-1:0]  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [2:0] track_state, [3] reinit_request, [7:4] zero
    output logic [M_TDATA_W-1:0]       m_tdata,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // input register
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    item_t   s_item;
    logic    s_fire;

    // result register
    logic    out_valid_reg, out_valid_next;
    state_t  out_state_reg;
    logic    out_reinit_reg;

    // core signals
    logic    advance;
    cfg_t    cfg;
    target_t prev;
    logic    same;
    state_t  cur_state;
    state_t  state_next;
    logic    reinit;

    // unpack the slave-side transfer
    assign s_item.has_target = s_tuser[0];
    assign s_item.spin_mode  = s_tuser[1];
    assign s_item.tgt.pos_x  = s_tdata[COORD_BITS-1:0];
    assign s_item.tgt.pos_y  = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_item.tgt.pos_z  = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign s_item.tgt.pix_x  = s_tdata[3*COORD_BITS+PIX_W-1:3*COORD_BITS];
    assign s_item.tgt.pix_y  = s_tdata[3*COORD_BITS+2*PIX_W-1:3*COORD_BITS+PIX_W];

    // the held detection moves into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_state_reg  <= state_next;
            out_reinit_reg <= reinit;
        end
    end

    tts_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tts_match u_match (
        .cur  (in_item_reg.tgt),
        .prev (prev),
        .cfg  (cfg),
        .same (same)
    );

    tts_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .same       (same),
        .miss_limit (cfg.miss_limit),
        .cur_state  (cur_state),
        .state_out  (state_next),
        .reinit     (reinit),
        .prev       (prev)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reinit_reg, out_state_reg};

    // a re-init request only comes with a first find or a switch
    a_reinit_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reinit_reg |->
            (out_state_reg == ST_FIRST || out_state_reg == ST_SWITCH))
        else $error("reinit flagged outside first find / switch");

    // a detection while lost always starts a new track with a re-init
    a_lost_find: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.has_target && cur_state == ST_LOST |=>
            out_state_reg == ST_FIRST && out_reinit_reg)
        else $error("lost track did not go to first find");

    // a missed frame after continue goes to buffering
    a_cont_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_item_reg.has_target && cur_state == ST_CONT |=>
            out_state_reg == ST_BUF && !out_reinit_reg)
        else $error("miss in continue did not go to buffering");

endmodule
`default_nettype wire

// ===== rtl/core/tts_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_cfg: configuration register file
// Holds the limits and keeps the squared distance limits alongside them.
// ----------------------------------------------------------------------------
module tts_cfg
    import tts_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    logic [LIM_W-1:0]     space_lim_reg;
    logic [LIM_SQ_W-1:0]  space_sq_reg;
    logic [PLIM_W-1:0]    pix_lim_reg;
    logic [PLIM_SQ_W-1:0] pix_sq_reg;
    logic [MISS_W-1:0]    miss_lim_reg;

    logic [LIM_W-1:0]  space_wr;
    logic [PLIM_W-1:0] pix_wr;

    assign space_wr = wr_data[LIM_W-1:0];
    assign pix_wr   = wr_data[PLIM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_lim_reg <= SPACE_LIMIT_RST;
            space_sq_reg  <= LIM_SQ_W'(SPACE_LIMIT_RST) * LIM_SQ_W'(SPACE_LIMIT_RST);
            pix_lim_reg   <= PIXEL_LIMIT_RST;
            pix_sq_reg    <= PLIM_SQ_W'(PIXEL_LIMIT_RST) * PLIM_SQ_W'(PIXEL_LIMIT_RST);
            miss_lim_reg  <= MISS_LIMIT_RST;
        end else if (wr_en) begin
            case (wr_index)
                CFG_SPACE_LIMIT: begin
                    space_lim_reg <= space_wr;
                    space_sq_reg  <= LIM_SQ_W'(space_wr) * LIM_SQ_W'(space_wr);
                end
                CFG_PIXEL_LIMIT: begin
                    pix_lim_reg <= pix_wr;
                    pix_sq_reg  <= PLIM_SQ_W'(pix_wr) * PLIM_SQ_W'(pix_wr);
                end
                CFG_MISS_LIMIT: begin
                    miss_lim_reg <= wr_data[MISS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pix_lim_reg itself is not passed on; only its square is used downstream
    assign cfg.space_lim    = space_lim_reg;
    assign cfg.space_lim_sq = space_sq_reg;
    assign cfg.pix_lim_sq   = (pix_lim_reg == '0) ? '0 : pix_sq_reg;
    assign cfg.miss_limit   = miss_lim_reg;

endmodule
`default_nettype wire

// ===== rtl/core/tts_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_match: same-target test
// Per-axis 3D offsets against the space limit, squared 3D and pixel distances against the squared limits.
// ----------------------------------------------------------------------------
module tts_match
    import tts_pkg::*;
(
    input  wire target_t cur,
    input  wire target_t prev,
    input  wire cfg_t    cfg,
    output logic         same
);

    logic [COORD_BITS:0]   diff_x, diff_y, diff_z;
    logic [COORD_BITS-1:0] dx, dy, dz;
    logic [SQ_W-1:0]       dx_sq, dy_sq, dz_sq;
    logic [SUM_W-1:0]      d_sum;
    logic [PIX_W-1:0]      ex, ey;
    logic [PSUM_W-1:0]     e_sum;
    logic                  axis_ok, space_ok, pix_ok;

    // sign-extended differences; magnitude always fits COORD_BITS
    assign diff_x = {cur.pos_x[COORD_BITS-1], cur.pos_x} - {prev.pos_x[COORD_BITS-1], prev.pos_x};
    assign diff_y = {cur.pos_y[COORD_BITS-1], cur.pos_y} - {prev.pos_y[COORD_BITS-1], prev.pos_y};
    assign diff_z = {cur.pos_z[COORD_BITS-1], cur.pos_z} - {prev.pos_z[COORD_BITS-1], prev.pos_z};

    assign dx = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign dy = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    assign dz = diff_z[COORD_BITS] ? COORD_BITS'(-diff_z) : diff_z[COORD_BITS-1:0];

    assign dx_sq = SQ_W'(dx) * SQ_W'(dx);
    assign dy_sq = SQ_W'(dy) * SQ_W'(dy);
    assign dz_sq = SQ_W'(dz) * SQ_W'(dz);
    assign d_sum = SUM_W'(dx_sq) + SUM_W'(dy_sq) + SUM_W'(dz_sq);

    assign axis_ok = (CMP_W'(dx) <= CMP_W'(cfg.space_lim)) &&
                     (CMP_W'(dy) <= CMP_W'(cfg.space_lim)) &&
                     (CMP_W'(dz) <= CMP_W'(cfg.space_lim));
    assign space_ok = SQ_CMP_W'(d_sum) <= SQ_CMP_W'(cfg.space_lim_sq);

    assign ex = (cur.pix_x > prev.pix_x) ? cur.pix_x - prev.pix_x : prev.pix_x - cur.pix_x;
    assign ey = (cur.pix_y > prev.pix_y) ? cur.pix_y - prev.pix_y : prev.pix_y - cur.pix_y;
    assign e_sum = PSUM_W'(ex) * PSUM_W'(ex) + PSUM_W'(ey) * PSUM_W'(ey);
    assign pix_ok = e_sum <= PSUM_W'(cfg.pix_lim_sq);

    assign same = axis_ok && space_ok && pix_ok;

endmodule
`default_nettype wire

// ===== rtl/core/tts_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_fsm: track state, miss counter and previous target
// Advances once per processed detection.
// ----------------------------------------------------------------------------
module tts_fsm
    import tts_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire item_t             item,
    input  wire logic              same,
    input  wire logic [MISS_W-1:0] miss_limit,
    output state_t                 cur_state,
    output state_t                 state_out,
    output logic                   reinit,
    output target_t                prev
);

    state_t            state_reg, state_next;
    logic [MISS_W-1:0] miss_reg, miss_next, miss_inc;
    target_t           prev_reg;

    assign miss_inc = (miss_reg == MISS_MAX) ? miss_reg : miss_reg + MISS_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        miss_next  = miss_reg;
        case (state_reg)
            ST_FIRST, ST_CONT, ST_SWITCH: begin
                if (item.has_target) begin
                    state_next = same ? ST_CONT : ST_SWITCH;
                end else if (state_reg != ST_FIRST) begin
                    state_next = ST_BUF;
                end
            end
            ST_BUF: begin
                // while buffering, a detection leaves state and miss count as they are
                if (!item.has_target) begin
                    if (miss_inc > miss_limit) begin
                        state_next = ST_LOST;
                        miss_next  = '0;
                    end else begin
                        miss_next = miss_inc;
                    end
                end
            end
            default: begin
                state_next = item.has_target ? ST_FIRST : ST_LOST;
            end
        endcase
    end

    // outputs
    always_comb begin
        case (state_reg)
            ST_FIRST, ST_CONT, ST_SWITCH: begin
                reinit = item.has_target && !same && !item.spin_mode;
            end
            ST_BUF: begin
                reinit = 1'b0;
            end
            default: begin
                reinit = item.has_target;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOST;
            miss_reg  <= '0;
            prev_reg  <= '0;
        end else if (step) begin
            state_reg <= state_next;
            miss_reg  <= miss_next;
            if (item.has_target) begin
                prev_reg <= item.tgt;
            end
        end
    end

    assign cur_state = state_reg;
    assign state_out = state_next;
    assign prev      = prev_reg;

endmodule
`default_nettype wire
